// ===== hw/rtl/cmu_pkg.sv =====
// ----------------------------------------------------------------------------
// cmu_pkg
// Shared types, operation codes and saturating 64-bit helpers for the
// complex 2x2 matrix unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cmu_pkg;

    // internal word of the arithmetic path
    localparam int XW = 64;

    typedef logic signed [XW-1:0] x64_t;

    typedef struct packed {
        x64_t re;
        x64_t im;
    } cx_t;

    // lane control group
    typedef struct packed {
        logic mac_en;
        logic clr;
        logic neg;
        logic div_start;
    } lane_ctl_t;

    // operation codes
    localparam logic [3:0] FN_LOAD   = 4'd0;
    localparam logic [3:0] FN_ADD    = 4'd1;
    localparam logic [3:0] FN_SUB    = 4'd2;
    localparam logic [3:0] FN_MUL    = 4'd3;
    localparam logic [3:0] FN_SCALE  = 4'd4;
    localparam logic [3:0] FN_DIV    = 4'd5;
    localparam logic [3:0] FN_INV    = 4'd6;
    localparam logic [3:0] FN_NEG    = 4'd7;
    localparam logic [3:0] FN_EQUAL  = 4'd8;
    localparam logic [3:0] FN_DET    = 4'd9;

    localparam x64_t X_MAX = {1'b0, {(XW-1){1'b1}}};
    localparam x64_t X_MIN = {1'b1, {(XW-1){1'b0}}};

    // saturating add on the internal word
    function automatic x64_t sadd(x64_t a, x64_t b);
        logic signed [XW:0] s;
        s = {a[XW-1], a} + {b[XW-1], b};
        if (s[XW] != s[XW-1])
            return s[XW] ? X_MIN : X_MAX;
        return s[XW-1:0];
    endfunction

    // saturating negate
    function automatic x64_t sneg(x64_t a);
        return (a == X_MIN) ? X_MAX : -a;
    endfunction

    // saturating multiply
    function automatic x64_t smul(x64_t a, x64_t b);
        logic signed [2*XW-1:0] p;
        p = a * b;
        if (p[2*XW-1:XW-1] != {(XW+1){p[2*XW-1]}})
            return p[2*XW-1] ? X_MIN : X_MAX;
        return p[XW-1:0];
    endfunction

    function automatic cx_t cmul(cx_t x, cx_t y);
        cx_t r;
        r.re = sadd(smul(x.re, y.re), sneg(smul(x.im, y.im)));
        r.im = sadd(smul(x.re, y.im), smul(x.im, y.re));
        return r;
    endfunction

    function automatic cx_t cadd(cx_t x, cx_t y);
        cx_t r;
        r.re = sadd(x.re, y.re);
        r.im = sadd(x.im, y.im);
        return r;
    endfunction

    function automatic cx_t cneg(cx_t x);
        cx_t r;
        r.re = sneg(x.re);
        r.im = sneg(x.im);
        return r;
    endfunction

    function automatic cx_t conj(cx_t x);
        cx_t r;
        r.re = x.re;
        r.im = sneg(x.im);
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cmu_in_if.sv =====
// ----------------------------------------------------------------------------
// cmu_in_if
// Request channel: operation code and operand matrix.
// ----------------------------------------------------------------------------
`default_nettype none

interface cmu_in_if #(
    parameter int COMP_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic [3:0]                   func;
    logic signed [COMP_WIDTH-1:0] x_a_re;
    logic signed [COMP_WIDTH-1:0] x_a_im;
    logic signed [COMP_WIDTH-1:0] x_b_re;
    logic signed [COMP_WIDTH-1:0] x_b_im;
    logic signed [COMP_WIDTH-1:0] x_c_re;
    logic signed [COMP_WIDTH-1:0] x_c_im;
    logic signed [COMP_WIDTH-1:0] x_d_re;
    logic signed [COMP_WIDTH-1:0] x_d_im;

    modport source (
        output valid, func, x_a_re, x_a_im, x_b_re, x_b_im,
               x_c_re, x_c_im, x_d_re, x_d_im,
        input  ready
    );

    modport sink (
        input  valid, func, x_a_re, x_a_im, x_b_re, x_b_im,
               x_c_re, x_c_im, x_d_re, x_d_im,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/cmu_out_if.sv =====
// ----------------------------------------------------------------------------
// cmu_out_if
// Result channel: accumulator, determinant and flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface cmu_out_if #(
    parameter int COMP_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COMP_WIDTH-1:0] m_a_re;
    logic signed [COMP_WIDTH-1:0] m_a_im;
    logic signed [COMP_WIDTH-1:0] m_b_re;
    logic signed [COMP_WIDTH-1:0] m_b_im;
    logic signed [COMP_WIDTH-1:0] m_c_re;
    logic signed [COMP_WIDTH-1:0] m_c_im;
    logic signed [COMP_WIDTH-1:0] m_d_re;
    logic signed [COMP_WIDTH-1:0] m_d_im;
    logic signed [COMP_WIDTH-1:0] det_re;
    logic signed [COMP_WIDTH-1:0] det_im;
    logic                         is_equal;
    logic                         singular;

    modport source (
        output valid, m_a_re, m_a_im, m_b_re, m_b_im, m_c_re, m_c_im,
               m_d_re, m_d_im, det_re, det_im, is_equal, singular,
        input  ready
    );

    modport sink (
        input  valid, m_a_re, m_a_im, m_b_re, m_b_im, m_c_re, m_c_im,
               m_d_re, m_d_im, det_re, det_im, is_equal, singular,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/complex_2x2_matrix_unit.sv =====
// ----------------------------------------------------------------------------
// complex_2x2_matrix_unit
// 2x2 complex fixed-point matrix accumulator: load, add, sub, mul, scale,
// divide, invert, negate, compare and determinant read.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  in_ch     in    valid/ready    func, x_a..x_d (re, im)
//  out_ch    out   valid/ready    m_a..m_d, det, is_equal, singular
//
//  one request at a time; four entry lanes plus a determinant lane
//  load/add/sub/scale/negate/equal/det: steps MAC1, WB, DET1, DET2, OUT; mul adds MAC2
//  divide: MAC1, then DIVS and DIVW (the serial dividers); invert adds MAC2 and INV
//  a zero divisor skips the dividers: DIVS goes straight to WB
//  reset loads the identity matrix
//  a stalled result holds the last stage; in_ch.ready is low until it leaves
// ----------------------------------------------------------------------------
`default_nettype none

module complex_2x2_matrix_unit #(
    parameter int COMP_WIDTH = 16,
    parameter int FRAC_BITS  = 11
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cmu_in_if.sink     in_ch,
    cmu_out_if.source  out_ch
);

    localparam int W = COMP_WIDTH;
    // multiplier operand width: entries, adjugate terms, rounded determinant
    localparam int OW_RAW = 2 * W - FRAC_BITS + 3;
    localparam int OW = (OW_RAW > W + 2) ? ((OW_RAW < 63) ? OW_RAW : 63) : W + 2;
    localparam cmu_pkg::x64_t MAXP64 = cmu_pkg::x64_t'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam cmu_pkg::x64_t MINN64 = -MAXP64 - 64'sd1;
    localparam cmu_pkg::x64_t HALF   = cmu_pkg::x64_t'(64'sd1 <<< (FRAC_BITS - 1));
    localparam cmu_pkg::x64_t ONE64  = cmu_pkg::x64_t'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [W-1:0] ONE_W = (ONE64 > MAXP64) ? MAXP64[W-1:0] : ONE64[W-1:0];

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_MAC1 = 10'b0000000010,
        S_MAC2 = 10'b0000000100,
        S_INV  = 10'b0000001000,
        S_DIVS = 10'b0000010000,
        S_DIVW = 10'b0000100000,
        S_WB   = 10'b0001000000,
        S_DET1 = 10'b0010000000,
        S_DET2 = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [W-1:0] acc_re_reg [4];
    logic signed [W-1:0] acc_im_reg [4];
    logic signed [W-1:0] x_re_reg [4];
    logic signed [W-1:0] x_im_reg [4];
    logic [3:0]          func_reg;
    logic                sing_reg, sing_next;
    logic                eq_reg, eq_next;
    logic                out_valid_reg;
    logic signed [W-1:0] m_re_reg [4];
    logic signed [W-1:0] m_im_reg [4];
    logic signed [W-1:0] det_re_reg, det_im_reg;
    logic                eq_out_reg, sing_out_reg;

    cmu_pkg::cx_t        acc_cx [4];
    cmu_pkg::cx_t        x_cx [4];
    cmu_pkg::cx_t        adj [4];
    cmu_pkg::cx_t        la [4];
    cmu_pkg::cx_t        lb [4];
    cmu_pkg::cx_t        lp [4];
    cmu_pkg::lane_ctl_t  lctl;
    cmu_pkg::lane_ctl_t  actl;
    cmu_pkg::cx_t        aa, ab, ap;
    cmu_pkg::cx_t        dcx;
    logic signed [W-1:0] lq_re [4];
    logic signed [W-1:0] lq_im [4];
    logic                lbusy [4];
    logic signed [W-1:0] nm_re [4];
    logic signed [W-1:0] nm_im [4];
    logic                in_acc, out_load;

    function automatic cmu_pkg::x64_t ext(logic signed [W-1:0] v);
        return {{(cmu_pkg::XW - W){v[W-1]}}, v};
    endfunction

    function automatic logic signed [W-1:0] sat_w(cmu_pkg::x64_t v);
        if (v > MAXP64)
            return MAXP64[W-1:0];
        if (v < MINN64)
            return MINN64[W-1:0];
        return v[W-1:0];
    endfunction

    function automatic cmu_pkg::x64_t rnd(cmu_pkg::x64_t v);
        return cmu_pkg::sadd(v, HALF) >>> FRAC_BITS;
    endfunction

    // extended views of the matrices
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            acc_cx[i].re = ext(acc_re_reg[i]);
            acc_cx[i].im = ext(acc_im_reg[i]);
            x_cx[i].re   = ext(x_re_reg[i]);
            x_cx[i].im   = ext(x_im_reg[i]);
        end
        adj[0] = acc_cx[3];
        adj[1] = cmu_pkg::cneg(acc_cx[1]);
        adj[2] = cmu_pkg::cneg(acc_cx[2]);
        adj[3] = acc_cx[0];
        dcx.re = rnd(ap.re);
        dcx.im = rnd(ap.im);
    end

    assign in_acc   = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ch.ready);

    // lane and determinant lane operand selection
    always_comb
    begin
        lctl = '0;
        actl = '0;
        aa   = acc_cx[0];
        ab   = acc_cx[3];
        for (int i = 0; i < 4; i++)
        begin
            la[i] = acc_cx[i];
            lb[i] = x_cx[0];
        end
        case (state_reg)
            S_MAC1:
            begin
                lctl.mac_en = 1'b1;
                lctl.clr    = 1'b1;
                actl.mac_en = 1'b1;
                actl.clr    = 1'b1;
                for (int i = 0; i < 4; i++)
                begin
                    if (func_reg == cmu_pkg::FN_MUL)
                    begin
                        la[i] = acc_cx[2 * (i >> 1)];
                        lb[i] = x_cx[i & 1];
                    end
                    else if (func_reg == cmu_pkg::FN_DIV)
                        lb[i] = cmu_pkg::conj(x_cx[0]);
                end
                if (func_reg == cmu_pkg::FN_DIV)
                begin
                    aa = x_cx[0];
                    ab = cmu_pkg::conj(x_cx[0]);
                end
            end
            S_MAC2:
            begin
                lctl.mac_en = 1'b1;
                actl.mac_en = 1'b1;
                actl.neg    = 1'b1;
                aa = acc_cx[1];
                ab = acc_cx[2];
                for (int i = 0; i < 4; i++)
                begin
                    la[i] = acc_cx[2 * (i >> 1) + 1];
                    lb[i] = x_cx[2 + (i & 1)];
                end
            end
            S_INV:
            begin
                lctl.mac_en = 1'b1;
                lctl.clr    = 1'b1;
                actl.mac_en = 1'b1;
                actl.clr    = 1'b1;
                aa = dcx;
                ab = cmu_pkg::conj(dcx);
                for (int i = 0; i < 4; i++)
                begin
                    la[i] = adj[i];
                    lb[i] = cmu_pkg::conj(dcx);
                end
            end
            S_DIVS:
                lctl.div_start = (ap.re != '0);
            S_DET1:
            begin
                actl.mac_en = 1'b1;
                actl.clr    = 1'b1;
            end
            S_DET2:
            begin
                actl.mac_en = 1'b1;
                actl.neg    = 1'b1;
                aa = acc_cx[1];
                ab = acc_cx[2];
            end
            default:
            begin
            end
        endcase
    end

    // four entry lanes
    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        cmu_lane #(.COMP_WIDTH(W), .FRAC_BITS(FRAC_BITS), .OW(OW)) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (lctl),
            .a     (la[g]),
            .b     (lb[g]),
            .den   (ap.re),
            .p     (lp[g]),
            .q_re  (lq_re[g]),
            .q_im  (lq_im[g]),
            .busy  (lbusy[g])
        );
    end

    // determinant and divisor lane
    cmu_mac #(.OW(OW)) u_aux (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (actl),
        .a     (aa),
        .b     (ab),
        .p     (ap)
    );

    // merge: new accumulator value per entry
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            nm_re[i] = acc_re_reg[i];
            nm_im[i] = acc_im_reg[i];
            case (func_reg)
                cmu_pkg::FN_LOAD:
                begin
                    nm_re[i] = x_re_reg[i];
                    nm_im[i] = x_im_reg[i];
                end
                cmu_pkg::FN_ADD:
                begin
                    nm_re[i] = sat_w(acc_cx[i].re + x_cx[i].re);
                    nm_im[i] = sat_w(acc_cx[i].im + x_cx[i].im);
                end
                cmu_pkg::FN_SUB:
                begin
                    nm_re[i] = sat_w(acc_cx[i].re - x_cx[i].re);
                    nm_im[i] = sat_w(acc_cx[i].im - x_cx[i].im);
                end
                cmu_pkg::FN_MUL, cmu_pkg::FN_SCALE:
                begin
                    nm_re[i] = sat_w(rnd(lp[i].re));
                    nm_im[i] = sat_w(rnd(lp[i].im));
                end
                cmu_pkg::FN_DIV, cmu_pkg::FN_INV:
                begin
                    if (!sing_reg)
                    begin
                        nm_re[i] = lq_re[i];
                        nm_im[i] = lq_im[i];
                    end
                end
                cmu_pkg::FN_NEG:
                begin
                    nm_re[i] = sat_w(-acc_cx[i].re);
                    nm_im[i] = sat_w(-acc_cx[i].im);
                end
                default:
                begin
                end
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        sing_next  = sing_reg;
        eq_next    = eq_reg;
        case (state_reg)
            S_IDLE:
                if (in_acc)
                    state_next = S_MAC1;
            S_MAC1:
            begin
                eq_next   = 1'b0;
                sing_next = 1'b0;
                if (func_reg == cmu_pkg::FN_EQUAL)
                begin
                    eq_next = 1'b1;
                    for (int i = 0; i < 4; i++)
                        if (acc_re_reg[i] != x_re_reg[i] || acc_im_reg[i] != x_im_reg[i])
                            eq_next = 1'b0;
                end
                case (func_reg)
                    cmu_pkg::FN_MUL, cmu_pkg::FN_INV: state_next = S_MAC2;
                    cmu_pkg::FN_DIV:                  state_next = S_DIVS;
                    default:                          state_next = S_WB;
                endcase
            end
            S_MAC2:
                state_next = (func_reg == cmu_pkg::FN_INV) ? S_INV : S_WB;
            S_INV:
                state_next = S_DIVS;
            S_DIVS:
            begin
                if (ap.re == '0)
                begin
                    sing_next  = 1'b1;
                    state_next = S_WB;
                end
                else
                    state_next = S_DIVW;
            end
            S_DIVW:
                if (!lbusy[0])
                    state_next = S_WB;
            S_WB:
                state_next = S_DET1;
            S_DET1:
                state_next = S_DET2;
            S_DET2:
                state_next = S_OUT;
            S_OUT:
                if (out_load)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sing_reg      <= 1'b0;
            eq_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                acc_re_reg[i] <= (i == 0 || i == 3) ? ONE_W : '0;
                acc_im_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            sing_reg  <= sing_next;
            eq_reg    <= eq_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            if (state_reg == S_WB)
                for (int i = 0; i < 4; i++)
                begin
                    acc_re_reg[i] <= nm_re[i];
                    acc_im_reg[i] <= nm_im[i];
                end
        end
    end

    // request capture and result register
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            func_reg    <= in_ch.func;
            x_re_reg[0] <= in_ch.x_a_re;
            x_im_reg[0] <= in_ch.x_a_im;
            x_re_reg[1] <= in_ch.x_b_re;
            x_im_reg[1] <= in_ch.x_b_im;
            x_re_reg[2] <= in_ch.x_c_re;
            x_im_reg[2] <= in_ch.x_c_im;
            x_re_reg[3] <= in_ch.x_d_re;
            x_im_reg[3] <= in_ch.x_d_im;
        end
        if (out_load)
        begin
            for (int i = 0; i < 4; i++)
            begin
                m_re_reg[i] <= acc_re_reg[i];
                m_im_reg[i] <= acc_im_reg[i];
            end
            det_re_reg   <= sat_w(rnd(ap.re));
            det_im_reg   <= sat_w(rnd(ap.im));
            eq_out_reg   <= eq_reg;
            sing_out_reg <= sing_reg;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.m_a_re   = m_re_reg[0];
    assign out_ch.m_a_im   = m_im_reg[0];
    assign out_ch.m_b_re   = m_re_reg[1];
    assign out_ch.m_b_im   = m_im_reg[1];
    assign out_ch.m_c_re   = m_re_reg[2];
    assign out_ch.m_c_im   = m_im_reg[2];
    assign out_ch.m_d_re   = m_re_reg[3];
    assign out_ch.m_d_im   = m_im_reg[3];
    assign out_ch.det_re   = det_re_reg;
    assign out_ch.det_im   = det_im_reg;
    assign out_ch.is_equal = eq_out_reg;
    assign out_ch.singular = sing_out_reg;

    // an accepted request always starts the first lane step
    a_start : assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg == S_MAC1) else $error("request not started");

    // singular only from divide or invert
    a_sing : assert property (@(posedge clk) disable iff (!rst_n)
        out_load && sing_reg |-> func_reg == cmu_pkg::FN_DIV || func_reg == cmu_pkg::FN_INV)
        else $error("singular on wrong operation");

    // equal and singular never together
    a_flags : assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !(eq_reg && sing_reg)) else $error("conflicting flags");

endmodule

`default_nettype wire

// ===== hw/rtl/cmu_mac.sv =====
// ----------------------------------------------------------------------------
// cmu_mac
// Complex multiply-accumulate: OW-bit operand multipliers, products and sums
// saturated on the 64-bit internal word.
// ----------------------------------------------------------------------------
`default_nettype none

module cmu_mac #(
    parameter int OW = 24
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmu_pkg::lane_ctl_t ctl,
    input  wire cmu_pkg::cx_t       a,
    input  wire cmu_pkg::cx_t       b,
    output cmu_pkg::cx_t            p
);

    localparam int PW = 2 * OW;

    cmu_pkg::cx_t prod;
    cmu_pkg::cx_t base;
    cmu_pkg::cx_t p_reg;
    cmu_pkg::cx_t p_next;

    // signed product of the low OW bits, saturated to the internal word
    function automatic cmu_pkg::x64_t nmul(cmu_pkg::x64_t x, cmu_pkg::x64_t y);
        logic signed [OW-1:0] xs;
        logic signed [OW-1:0] ys;
        logic signed [PW-1:0] pr;
        logic signed [127:0]  pw;
        xs = x[OW-1:0];
        ys = y[OW-1:0];
        pr = xs * ys;
        pw = {{(128 - PW){pr[PW-1]}}, pr};
        if (pw[127:cmu_pkg::XW-1] != {(129 - cmu_pkg::XW){pw[127]}})
            return pw[127] ? cmu_pkg::X_MIN : cmu_pkg::X_MAX;
        return pw[cmu_pkg::XW-1:0];
    endfunction

    function automatic cmu_pkg::cx_t ncmul(cmu_pkg::cx_t x, cmu_pkg::cx_t y);
        cmu_pkg::cx_t r;
        r.re = cmu_pkg::sadd(nmul(x.re, y.re), cmu_pkg::sneg(nmul(x.im, y.im)));
        r.im = cmu_pkg::sadd(nmul(x.re, y.im), nmul(x.im, y.re));
        return r;
    endfunction

    // product, optional negate, accumulate
    always_comb
    begin
        prod   = ncmul(a, b);
        if (ctl.neg)
            prod = cmu_pkg::cneg(prod);
        base   = ctl.clr ? '0 : p_reg;
        p_next = cmu_pkg::cadd(base, prod);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_reg <= '0;
        else if (ctl.mac_en)
            p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/cmu_div.sv =====
// ----------------------------------------------------------------------------
// cmu_div
// Bit-serial restoring divider: round(num * 2^FRAC_BITS / den), ties away
// from zero, saturated to COMP_WIDTH bits. One quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cmu_div #(
    parameter int COMP_WIDTH = 16,
    parameter int FRAC_BITS  = 11
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire cmu_pkg::x64_t                num,
    input  wire cmu_pkg::x64_t                den,
    output logic                              busy,
    output logic signed [COMP_WIDTH-1:0]      q
);

    localparam int NW = cmu_pkg::XW + FRAC_BITS + 1;
    localparam int DW = NW + COMP_WIDTH + 2;
    localparam int QW = COMP_WIDTH + 1;
    localparam int CW = $clog2(COMP_WIDTH + 2);
    localparam logic [QW:0] MAXP = {2'b00, {(COMP_WIDTH-1){1'b1}}};
    localparam logic [QW:0] MINM = {2'b01, {(COMP_WIDTH-1){1'b0}}};

    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dsh_reg, dsh_next;
    logic [QW-1:0] q_reg, q_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          ovf_reg, ovf_next;
    logic          neg_reg, neg_next;
    logic [cmu_pkg::XW-1:0] mag;
    logic [DW-1:0] n_init;
    logic [DW-1:0] d_ext;
    logic [QW:0]   qr;

    // load and one restoring step per cycle
    always_comb
    begin
        mag       = num[cmu_pkg::XW-1] ? (~num + 1'b1) : num;
        n_init    = DW'(mag) << (FRAC_BITS + 1);
        d_ext     = DW'(den[cmu_pkg::XW-2:0]);
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        ovf_next  = ovf_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            rem_next  = n_init;
            dsh_next  = d_ext << COMP_WIDTH;
            ovf_next  = n_init >= (d_ext << (COMP_WIDTH + 1));
            neg_next  = num[cmu_pkg::XW-1];
            q_next    = '0;
            cnt_next  = CW'(COMP_WIDTH + 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_next = rem_reg - dsh_reg;
                q_next   = {q_reg[QW-2:0], 1'b1};
            end
            else
                q_next = {q_reg[QW-2:0], 1'b0};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
        neg_reg <= neg_next;
    end

    // round half away and saturate
    always_comb
    begin
        qr = ({1'b0, q_reg} + 1'b1) >> 1;
        if (!neg_reg)
            q = (ovf_reg || qr > MAXP) ? MAXP[COMP_WIDTH-1:0] : qr[COMP_WIDTH-1:0];
        else
            q = (ovf_reg || qr > MINM) ? MINM[COMP_WIDTH-1:0]
                                       : COMP_WIDTH'(-qr);
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/cmu_lane.sv =====
// ----------------------------------------------------------------------------
// cmu_lane
// One matrix entry lane: complex multiply-accumulate and two dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module cmu_lane #(
    parameter int COMP_WIDTH = 16,
    parameter int FRAC_BITS  = 11,
    parameter int OW         = 24
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire cmu_pkg::lane_ctl_t           ctl,
    input  wire cmu_pkg::cx_t                 a,
    input  wire cmu_pkg::cx_t                 b,
    input  wire cmu_pkg::x64_t                den,
    output cmu_pkg::cx_t                      p,
    output logic signed [COMP_WIDTH-1:0]      q_re,
    output logic signed [COMP_WIDTH-1:0]      q_im,
    output logic                              busy
);

    logic busy_im;

    cmu_mac #(.OW(OW)) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .a     (a),
        .b     (b),
        .p     (p)
    );

    // real and imaginary quotients in step
    cmu_div #(.COMP_WIDTH(COMP_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_re (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.div_start),
        .num   (p.re),
        .den   (den),
        .busy  (busy),
        .q     (q_re)
    );

    cmu_div #(.COMP_WIDTH(COMP_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_im (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.div_start),
        .num   (p.im),
        .den   (den),
        .busy  (busy_im),
        .q     (q_im)
    );

    assign_check_unused : assert property (@(posedge clk) disable iff (!rst_n)
        busy == busy_im) else $error("lane dividers out of step");

endmodule

`default_nettype wire
